// ===== src/smcd_pkg.sv =====
// Shared types and constants for the serial motor command decoder.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps

package smcd_pkg;

    // Longest line, terminator excluded, is LINE_CAPACITY - 1 bytes.
    localparam int LINE_CAPACITY = 32;
    localparam int LEN_W         = $clog2(LINE_CAPACITY);

    // Depth of the command queue between the parser and the executor.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Characters of interest.
    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_VT    = 8'd11;
    localparam logic [7:0] CH_FF    = 8'd12;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_COLON = 8'd58;
    localparam logic [7:0] CH_A     = 8'd65;
    localparam logic [7:0] CH_D     = 8'd68;
    localparam logic [7:0] CH_E     = 8'd69;
    localparam logic [7:0] CH_M     = 8'd77;
    localparam logic [7:0] CH_P     = 8'd80;
    localparam logic [7:0] CH_R     = 8'd82;
    localparam logic [7:0] CH_W     = 8'd87;

    localparam logic [7:0] DUTY_LIMIT_RESET = 8'd255;

    // Drive pin patterns: bit0 pin A, bit1 pin B.
    localparam logic [1:0] PINS_STOP = 2'd0;
    localparam logic [1:0] PINS_REV  = 2'd1;
    localparam logic [1:0] PINS_FWD  = 2'd2;

    typedef enum logic [1:0] {
        KIND_DUTY    = 2'd0,
        KIND_READ    = 2'd1,
        KIND_UNKNOWN = 2'd2
    } reply_kind_t;

    // One classified command line.
    typedef struct packed {
        reply_kind_t        kind;
        logic signed [15:0] request;
        logic signed [15:0] encoder;
    } cmd_t;

    typedef struct packed {
        logic push;
        cmd_t cmd;
    } q_wr_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_rd_t;

endpackage

// ===== src/smcd_front.sv =====
// Line parser: matches received bytes incrementally and classifies each line.
// Depends on smcd_pkg.
`timescale 1ns / 1ps

module smcd_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 byte_accept,
    input  logic [7:0]           rx_byte,
    input  logic signed [15:0]   encoder_now,
    output smcd_pkg::q_wr_t      q_wr
);

    typedef enum logic [3:0] {
        PH_START, PH_P, PH_PW, PH_PWM, PH_NUMBER,
        PH_R, PH_RE, PH_REA, PH_READ_DONE, PH_OTHER
    } match_phase_t;

    typedef enum logic [1:0] {
        NUM_SKIP, NUM_SIGN, NUM_DIGITS, NUM_DONE
    } number_phase_t;

    logic [smcd_pkg::LEN_W-1:0] len_reg, len_next;
    match_phase_t               phase_reg, phase_next;
    number_phase_t              num_reg, num_next;
    logic [15:0]                accum_reg, accum_next;
    logic                       neg_reg, neg_next;
    logic                       ended_reg, ended_next;

    logic                       is_digit;
    logic [15:0]                digit_val;
    logic [15:0]                raw;
    logic                       clear_line;

    assign is_digit  = (rx_byte >= smcd_pkg::CH_ZERO) && (rx_byte <= smcd_pkg::CH_NINE);
    assign digit_val = {8'd0, rx_byte - smcd_pkg::CH_ZERO};
    assign raw       = neg_reg ? (16'd0 - accum_reg) : accum_reg;

    always_comb begin
        len_next    = len_reg;
        phase_next  = phase_reg;
        num_next    = num_reg;
        accum_next  = accum_reg;
        neg_next    = neg_reg;
        ended_next  = ended_reg;
        clear_line  = 1'b0;
        q_wr.push   = 1'b0;
        q_wr.cmd.kind    = smcd_pkg::KIND_UNKNOWN;
        q_wr.cmd.request = '0;
        q_wr.cmd.encoder = '0;

        if (byte_accept) begin
            if (rx_byte != smcd_pkg::CH_LF && rx_byte != smcd_pkg::CH_CR) begin
                if (len_reg < smcd_pkg::LEN_W'(smcd_pkg::LINE_CAPACITY - 1)) begin
                    len_next = len_reg + 1'b1;
                    if (!ended_reg) begin
                        if (rx_byte == smcd_pkg::CH_NUL) begin
                            ended_next = 1'b1;
                        end else begin
                            case (phase_reg)
                                PH_START: begin
                                    if (rx_byte == smcd_pkg::CH_P)      phase_next = PH_P;
                                    else if (rx_byte == smcd_pkg::CH_R) phase_next = PH_R;
                                    else                                phase_next = PH_OTHER;
                                end
                                PH_P:   phase_next = (rx_byte == smcd_pkg::CH_W) ? PH_PW : PH_OTHER;
                                PH_PW:  phase_next = (rx_byte == smcd_pkg::CH_M) ? PH_PWM : PH_OTHER;
                                PH_PWM: begin
                                    phase_next = (rx_byte == smcd_pkg::CH_COLON) ? PH_NUMBER
                                                                                 : PH_OTHER;
                                end
                                PH_R:   phase_next = (rx_byte == smcd_pkg::CH_E) ? PH_RE : PH_OTHER;
                                PH_RE:  phase_next = (rx_byte == smcd_pkg::CH_A) ? PH_REA : PH_OTHER;
                                PH_REA: begin
                                    phase_next = (rx_byte == smcd_pkg::CH_D) ? PH_READ_DONE
                                                                             : PH_OTHER;
                                end
                                PH_NUMBER: begin
                                    case (num_reg)
                                        NUM_SKIP: begin
                                            if (rx_byte inside {smcd_pkg::CH_SPACE,
                                                                smcd_pkg::CH_TAB,
                                                                smcd_pkg::CH_VT,
                                                                smcd_pkg::CH_FF}) begin
                                                num_next = NUM_SKIP;
                                            end else if (rx_byte == smcd_pkg::CH_PLUS) begin
                                                num_next = NUM_SIGN;
                                            end else if (rx_byte == smcd_pkg::CH_MINUS) begin
                                                neg_next = 1'b1;
                                                num_next = NUM_SIGN;
                                            end else if (is_digit) begin
                                                accum_next = digit_val;
                                                num_next   = NUM_DIGITS;
                                            end else begin
                                                num_next = NUM_DONE;
                                            end
                                        end
                                        NUM_SIGN, NUM_DIGITS: begin
                                            if (is_digit) begin
                                                // times ten as two shifts, wraps at 16 bits
                                                accum_next = (accum_reg << 3) + (accum_reg << 1)
                                                           + digit_val;
                                                num_next   = NUM_DIGITS;
                                            end else begin
                                                num_next = NUM_DONE;
                                            end
                                        end
                                        default: num_next = num_reg;
                                    endcase
                                end
                                default: phase_next = PH_OTHER;
                            endcase
                        end
                    end
                end else begin
                    // overlong line: drop it and start over
                    clear_line = 1'b1;
                end
            end else begin
                if (len_reg != '0) begin
                    q_wr.push = 1'b1;
                    case (phase_reg)
                        PH_NUMBER: begin
                            q_wr.cmd.kind    = smcd_pkg::KIND_DUTY;
                            q_wr.cmd.request = raw;
                            q_wr.cmd.encoder = encoder_now;
                        end
                        PH_READ_DONE: begin
                            q_wr.cmd.kind    = smcd_pkg::KIND_READ;
                            q_wr.cmd.encoder = encoder_now;
                        end
                        default: q_wr.cmd.kind = smcd_pkg::KIND_UNKNOWN;
                    endcase
                end
                clear_line = 1'b1;
            end
        end

        if (clear_line) begin
            len_next   = '0;
            phase_next = PH_START;
            num_next   = NUM_SKIP;
            accum_next = '0;
            neg_next   = 1'b0;
            ended_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg   <= '0;
            phase_reg <= PH_START;
            num_reg   <= NUM_SKIP;
            accum_reg <= '0;
            neg_reg   <= 1'b0;
            ended_reg <= 1'b0;
        end else begin
            len_reg   <= len_next;
            phase_reg <= phase_next;
            num_reg   <= num_next;
            accum_reg <= accum_next;
            neg_reg   <= neg_next;
            ended_reg <= ended_next;
        end
    end

endmodule

// ===== src/smcd_queue.sv =====
// Small command queue decoupling the line parser from the executor.
// Depends on smcd_pkg.
`timescale 1ns / 1ps

module smcd_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  smcd_pkg::q_wr_t  q_wr,
    input  logic             pop,
    output smcd_pkg::q_rd_t  q_rd,
    output logic             full
);

    smcd_pkg::cmd_t                 mem [smcd_pkg::QUEUE_DEPTH];
    logic [smcd_pkg::QPTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [smcd_pkg::QCNT_W-1:0]    count_reg;
    logic                           do_pop;

    assign full       = (count_reg == smcd_pkg::QCNT_W'(smcd_pkg::QUEUE_DEPTH));
    assign q_rd.valid = (count_reg != '0);
    assign q_rd.cmd   = mem[rd_ptr_reg];
    assign do_pop     = pop && q_rd.valid;

    always_ff @(posedge aclk) begin
        if (q_wr.push) begin
            mem[wr_ptr_reg] <= q_wr.cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (q_wr.push) begin
                wr_ptr_reg <= (wr_ptr_reg == smcd_pkg::QPTR_W'(smcd_pkg::QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == smcd_pkg::QPTR_W'(smcd_pkg::QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            end
            if (q_wr.push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (!q_wr.push && do_pop) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= smcd_pkg::QCNT_W'(smcd_pkg::QUEUE_DEPTH))
        else $error("queue count exceeds depth");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full && !do_pop |-> !q_wr.push)
        else $error("push into a full queue");

    a_count_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        q_wr.push && !do_pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not advance on push");
`endif

endmodule

// ===== src/smcd_back.sv =====
// Command executor: clamps duty requests, updates motor state, holds the reply.
// Depends on smcd_pkg.
`timescale 1ns / 1ps

module smcd_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  smcd_pkg::q_rd_t     q_rd,
    output logic                pop,
    input  logic                cfg_write,
    input  logic [7:0]          cfg_limit,
    output logic                out_valid,
    input  logic                out_ready,
    output smcd_pkg::reply_kind_t out_kind,
    output logic signed [15:0]  out_request,
    output logic signed [15:0]  out_encoder,
    output logic [7:0]          duty,
    output logic                reverse,
    output logic [1:0]          pins
);

    logic [7:0]                 limit_reg;
    logic                       valid_reg;
    smcd_pkg::reply_kind_t      kind_reg;
    logic signed [15:0]         request_reg;
    logic signed [15:0]         encoder_reg;
    logic [7:0]                 duty_reg, duty_next;
    logic                       dir_reg, dir_next;
    logic [1:0]                 pins_reg, pins_next;

    logic signed [16:0]         req_s, lim_s, nlim_s, clamp_s, mag_s;

    // Take a command whenever the reply slot is empty or being drained.
    assign pop = q_rd.valid && (!valid_reg || out_ready);

    always_comb begin
        req_s  = {q_rd.cmd.request[15], q_rd.cmd.request};
        lim_s  = {9'd0, limit_reg};
        nlim_s = -lim_s;
        if (req_s > lim_s)       clamp_s = lim_s;
        else if (req_s < nlim_s) clamp_s = nlim_s;
        else                     clamp_s = req_s;
        mag_s  = clamp_s[16] ? -clamp_s : clamp_s;

        duty_next = duty_reg;
        dir_next  = dir_reg;
        pins_next = pins_reg;
        if (pop && q_rd.cmd.kind == smcd_pkg::KIND_DUTY) begin
            duty_next = mag_s[7:0];
            if (clamp_s > 17'sd0) begin
                dir_next  = 1'b0;
                pins_next = smcd_pkg::PINS_FWD;
            end else if (clamp_s < 17'sd0) begin
                dir_next  = 1'b1;
                pins_next = smcd_pkg::PINS_REV;
            end else begin
                pins_next = smcd_pkg::PINS_STOP;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= smcd_pkg::DUTY_LIMIT_RESET;
            valid_reg <= 1'b0;
            duty_reg  <= '0;
            dir_reg   <= 1'b0;
            pins_reg  <= smcd_pkg::PINS_STOP;
        end else begin
            if (cfg_write) begin
                limit_reg <= cfg_limit;
            end
            if (pop) begin
                valid_reg <= 1'b1;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
            duty_reg <= duty_next;
            dir_reg  <= dir_next;
            pins_reg <= pins_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            kind_reg    <= q_rd.cmd.kind;
            request_reg <= q_rd.cmd.request;
            encoder_reg <= q_rd.cmd.encoder;
        end
    end

    assign out_valid   = valid_reg;
    assign out_kind    = kind_reg;
    assign out_request = request_reg;
    assign out_encoder = encoder_reg;
    assign duty        = duty_reg;
    assign reverse     = dir_reg;
    assign pins        = pins_reg;

`ifndef SYNTHESIS
    a_stop_iff_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (pins_reg == smcd_pkg::PINS_STOP) == (duty_reg == 8'd0))
        else $error("drive pins disagree with duty");

    a_pins_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        pins_reg != 2'd3)
        else $error("both drive pins high");

    a_state_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        !pop |=> $stable(duty_reg) && $stable(dir_reg) && $stable(pins_reg))
        else $error("motor state changed without a command");
`endif

endmodule

// ===== src/serial_motor_command_decoder.sv =====
// Top level of the serial motor command decoder.
// Depends on smcd_pkg, smcd_front, smcd_queue and smcd_back.
// A line-ending byte is queued, then taken into the reply register behind m_tvalid once free.
// Throughput: one byte per cycle while the queue is not full; the parser updates its match state once per byte.
// Reset: aresetn is synchronous and active low; it clears the line state, the motor
// state (duty 0, forward, pins low), the queue and sets duty_limit to 255.
`timescale 1ns / 1ps

module serial_motor_command_decoder (
    input  logic        aclk,
    input  logic        aresetn,

    // Byte stream in.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] rx_byte, [23:8] encoder_now

    // Duty limit register write.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,  // duty_limit

    // Reply stream out.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [15:0] echoed_request, [31:16] encoder_reported,
                                   // [39:32] duty_out, [40] reverse_dir, [42:41] drive_pins,
                                   // [47:43] zero
    output logic [1:0]  m_tuser    // [1:0] reply_kind
);

    smcd_pkg::q_wr_t        q_wr;
    smcd_pkg::q_rd_t        q_rd;
    logic                   q_full;
    logic                   pop;
    logic                   byte_accept;

    smcd_pkg::reply_kind_t  out_kind;
    logic signed [15:0]     out_request;
    logic signed [15:0]     out_encoder;
    logic [7:0]             duty;
    logic                   reverse;
    logic [1:0]             pins;

    // Hold off bytes only while the queue is full; a line end may push.
    assign s_tready    = !q_full;
    assign byte_accept = s_tvalid && s_tready;

    // The limit register takes a write in any cycle.
    assign cfg_ready = 1'b1;

    smcd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_accept (byte_accept),
        .rx_byte     (s_tdata[7:0]),
        .encoder_now (s_tdata[23:8]),
        .q_wr        (q_wr)
    );

    smcd_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_wr    (q_wr),
        .pop     (pop),
        .q_rd    (q_rd),
        .full    (q_full)
    );

    smcd_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_rd        (q_rd),
        .pop         (pop),
        .cfg_write   (cfg_valid && cfg_ready),
        .cfg_limit   (cfg_data),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_kind    (out_kind),
        .out_request (out_request),
        .out_encoder (out_encoder),
        .duty        (duty),
        .reverse     (reverse),
        .pins        (pins)
    );

    // Pack the reply; pad to whole bytes with zeros.
    assign m_tdata = {5'd0, pins, reverse, duty, out_encoder, out_request};
    assign m_tuser = out_kind;

endmodule
